/* src/cmt_pkg.sv */
// Shared types, constants and helpers for the chat mention token classifier.
`default_nettype none
package cmt_pkg;

  localparam int MAX_WORD_LEN = 256;
  localparam int POS_W        = $clog2(MAX_WORD_LEN + 1);
  localparam int CP_W         = $clog2(MAX_WORD_LEN);
  localparam int CHAR_W       = 8;
  localparam int OUT_W        = 8;

  localparam logic [CHAR_W-1:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [CHAR_W-1:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [CHAR_W-1:0] CH_AT    = 8'h40;  // '@'
  localparam logic [CHAR_W-1:0] CH_BANG  = 8'h21;  // '!'
  localparam logic [CHAR_W-1:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [CHAR_W-1:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;  // ':'
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [2:0] {
    TOK_PLAIN    = 3'd0,
    TOK_USER     = 3'd1,
    TOK_NICK     = 3'd2,
    TOK_ROLE     = 3'd3,
    TOK_CHANNEL  = 3'd4,
    TOK_EMOJI    = 3'd5,
    TOK_ANIMATED = 3'd6
  } tok_type_t;

  typedef struct packed {
    logic [CHAR_W-1:0] byte_in;
    logic              last_byte;
  } char_word_t;

  typedef struct packed {
    tok_type_t        token_type;
    logic [OUT_W-1:0] id_start;
    logic [OUT_W-1:0] id_length;
    logic [OUT_W-1:0] name_start;
    logic [OUT_W-1:0] name_length;
  } token_word_t;

  // word state as seen by the classifier on the closing byte
  typedef struct packed {
    logic [CHAR_W-1:0] cur_char;
    logic [POS_W-1:0]  len;
    logic              too_long;
    logic [CHAR_W-1:0] first_char;
    logic [CHAR_W-1:0] second_char;
    logic [CHAR_W-1:0] third_char;
    logic              digits_from_two;
    logic              digits_from_three;
    logic [1:0]        colon_tally;
    logic [CP_W-1:0]   inner_colon_pos;
    logic              digits_after_colon;
  } cmt_snap_t;

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage
`default_nettype wire

/* src/cmt_tracker.sv */
// Per-word state: byte position, leading bytes, digit and colon tracking.
`default_nettype none
module cmt_tracker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               take,
  input  wire cmt_pkg::char_word_t data,
  output cmt_pkg::cmt_snap_t      snap
);

  logic [cmt_pkg::POS_W-1:0]  position;
  logic [cmt_pkg::CHAR_W-1:0] first_char;
  logic [cmt_pkg::CHAR_W-1:0] second_char;
  logic [cmt_pkg::CHAR_W-1:0] third_char;
  logic                       digits_from_two;
  logic                       digits_from_three;
  logic [1:0]                 colon_tally;
  logic [cmt_pkg::CP_W-1:0]   inner_colon_pos;
  logic                       digits_after_colon;

  logic full;
  logic dig;
  logic inner;

  assign full  = (position == cmt_pkg::POS_W'(cmt_pkg::MAX_WORD_LEN));
  assign dig   = cmt_pkg::is_digit(data.byte_in);
  assign inner = !full && !data.last_byte && (position >= cmt_pkg::POS_W'(1));

  always_ff @(posedge clk) begin
    if (rst || (take && data.last_byte)) begin
      position           <= '0;
      first_char         <= '0;
      second_char        <= '0;
      third_char         <= '0;
      digits_from_two    <= 1'b1;
      digits_from_three  <= 1'b1;
      colon_tally        <= '0;
      inner_colon_pos    <= '0;
      digits_after_colon <= 1'b1;
    end else if (take && !full) begin
      position <= position + cmt_pkg::POS_W'(1);
      if (position == cmt_pkg::POS_W'(0)) first_char  <= data.byte_in;
      if (position == cmt_pkg::POS_W'(1)) second_char <= data.byte_in;
      if (position == cmt_pkg::POS_W'(2)) third_char  <= data.byte_in;
      if (inner) begin
        if (position >= cmt_pkg::POS_W'(2) && !dig) digits_from_two   <= 1'b0;
        if (position >= cmt_pkg::POS_W'(3) && !dig) digits_from_three <= 1'b0;
        if (data.byte_in == cmt_pkg::CH_COLON) begin
          if (colon_tally != 2'd3) colon_tally <= colon_tally + 2'd1;
          inner_colon_pos    <= position[cmt_pkg::CP_W-1:0];
          digits_after_colon <= 1'b1;
        end else if (!dig) begin
          digits_after_colon <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    snap.cur_char           = data.byte_in;
    snap.len                = position + cmt_pkg::POS_W'(1);
    snap.too_long           = full;
    snap.first_char         = first_char;
    snap.second_char        = second_char;
    snap.third_char         = third_char;
    snap.digits_from_two    = digits_from_two;
    snap.digits_from_three  = digits_from_three;
    snap.colon_tally        = colon_tally;
    snap.inner_colon_pos    = inner_colon_pos;
    snap.digits_after_colon = digits_after_colon;
  end

endmodule
`default_nettype wire

/* src/cmt_classify.sv */
// Decodes the word state on the closing byte into a token word.
`default_nettype none
module cmt_classify (
  input  wire cmt_pkg::cmt_snap_t snap,
  output cmt_pkg::token_word_t    tok
);

  localparam int EW = cmt_pkg::POS_W + 1;

  logic [cmt_pkg::POS_W-1:0] cp;
  logic [EW-1:0]             id_len;
  logic                      id_ok;
  logic                      framed;

  assign cp     = cmt_pkg::POS_W'(snap.inner_colon_pos);
  assign id_len = EW'(snap.len) - EW'(cp) - EW'(2);
  assign id_ok  = !id_len[EW-1] && (id_len != '0);
  assign framed = !snap.too_long && (snap.len >= cmt_pkg::POS_W'(4)) &&
                  (snap.first_char == cmt_pkg::CH_LT) && (snap.cur_char == cmt_pkg::CH_GT);

  always_comb begin
    tok = '{cmt_pkg::TOK_PLAIN, '0, '0, '0, '0};
    if (framed) begin
      if (snap.second_char == cmt_pkg::CH_AT) begin
        if (snap.digits_from_two) begin
          tok.token_type = cmt_pkg::TOK_USER;
          tok.id_start   = cmt_pkg::OUT_W'(2);
          tok.id_length  = cmt_pkg::OUT_W'(snap.len - cmt_pkg::POS_W'(3));
        end else if (snap.len > cmt_pkg::POS_W'(4) && snap.digits_from_three) begin
          if (snap.third_char == cmt_pkg::CH_BANG) begin
            tok.token_type = cmt_pkg::TOK_NICK;
            tok.id_start   = cmt_pkg::OUT_W'(3);
            tok.id_length  = cmt_pkg::OUT_W'(snap.len - cmt_pkg::POS_W'(4));
          end else if (snap.third_char == cmt_pkg::CH_AMP) begin
            tok.token_type = cmt_pkg::TOK_ROLE;
            tok.id_start   = cmt_pkg::OUT_W'(3);
            tok.id_length  = cmt_pkg::OUT_W'(snap.len - cmt_pkg::POS_W'(4));
          end
        end
      end else if (snap.second_char == cmt_pkg::CH_HASH && snap.digits_from_two) begin
        tok.token_type = cmt_pkg::TOK_CHANNEL;
        tok.id_start   = cmt_pkg::OUT_W'(2);
        tok.id_length  = cmt_pkg::OUT_W'(snap.len - cmt_pkg::POS_W'(3));
      end else if (snap.len > cmt_pkg::POS_W'(5) && snap.colon_tally == 2'd2) begin
        if (snap.second_char == cmt_pkg::CH_COLON) begin
          if (cp > cmt_pkg::POS_W'(2) && id_ok && snap.digits_after_colon) begin
            tok.token_type  = cmt_pkg::TOK_EMOJI;
            tok.name_start  = cmt_pkg::OUT_W'(2);
            tok.name_length = cmt_pkg::OUT_W'(cp - cmt_pkg::POS_W'(2));
            tok.id_start    = cmt_pkg::OUT_W'(cp + cmt_pkg::POS_W'(1));
            tok.id_length   = cmt_pkg::OUT_W'(id_len);
          end
        end else if (snap.len > cmt_pkg::POS_W'(6) && snap.second_char == cmt_pkg::CH_LA &&
                     snap.third_char == cmt_pkg::CH_COLON) begin
          if (cp > cmt_pkg::POS_W'(3) && id_ok && snap.digits_after_colon) begin
            tok.token_type  = cmt_pkg::TOK_ANIMATED;
            tok.name_start  = cmt_pkg::OUT_W'(3);
            tok.name_length = cmt_pkg::OUT_W'(cp - cmt_pkg::POS_W'(3));
            tok.id_start    = cmt_pkg::OUT_W'(cp + cmt_pkg::POS_W'(1));
            tok.id_length   = cmt_pkg::OUT_W'(id_len);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/chat_mention_token_classifier.sv */
// Top level of the chat mention token classifier.
// Takes one byte word per cycle while char_stall is low; on the word flagged last_byte
// the token class and the id and name offsets/lengths appear on the token channel on
// the next cycle. The per-word state registers update and the classifier feeds a
// single result register, so bytes stream at full rate as long as the token side is
// not stalling a held result. Words longer than 256 bytes classify as plain.
`default_nettype none
module chat_mention_token_classifier (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 char_valid,
  output logic                      char_stall,
  input  wire cmt_pkg::char_word_t  char_data,
  output logic                      token_valid,
  input  wire logic                 token_stall,
  output cmt_pkg::token_word_t      token_data
);

  logic                 take;
  cmt_pkg::cmt_snap_t   snap;
  cmt_pkg::token_word_t tok;

  assign char_stall = token_valid && token_stall;
  assign take       = char_valid && !char_stall;

  cmt_tracker u_tracker (
    .clk  (clk),
    .rst  (rst),
    .take (take),
    .data (char_data),
    .snap (snap)
  );

  cmt_classify u_classify (
    .snap (snap),
    .tok  (tok)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      token_valid <= 1'b0;
    end else if (take && char_data.last_byte) begin
      token_valid <= 1'b1;
    end else if (!token_stall) begin
      token_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && char_data.last_byte) begin
      token_data <= tok;
    end
  end

endmodule
`default_nettype wire

/* src/cmt_checker.sv */
// Port-level checks for the chat mention token classifier, bound to the top level.
`default_nettype none
module cmt_checker (
  input wire logic                 clk,
  input wire logic                 rst,
  input wire logic                 char_valid,
  input wire logic                 char_stall,
  input wire cmt_pkg::char_word_t  char_data,
  input wire logic                 token_valid,
  input wire logic                 token_stall,
  input wire cmt_pkg::token_word_t token_data
);

  logic char_take;
  assign char_take = char_valid && !char_stall;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |=> token_valid && $stable(token_data))
    else $error("stalled token word changed");

  a_result: assert property (@(posedge clk) disable iff (rst)
    char_take && char_data.last_byte |=> token_valid)
    else $error("closing byte gave no token word");

  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    !token_valid && !(char_take && char_data.last_byte) |=> !token_valid)
    else $error("token word without closing byte");

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    token_valid && token_stall |-> char_stall)
    else $error("byte taken while token word held");

endmodule

bind chat_mention_token_classifier cmt_checker u_cmt_checker (
  .clk         (clk),
  .rst         (rst),
  .char_valid  (char_valid),
  .char_stall  (char_stall),
  .char_data   (char_data),
  .token_valid (token_valid),
  .token_stall (token_stall),
  .token_data  (token_data)
);
`default_nettype wire
